### design/rtpwl_pkg.sv
// ----------------------------------------------------------------------------
// rtpwl_pkg: shared constants for the resistance-to-temperature converter
// Holds the fixed calibration points, segment slopes and output widths.
// ----------------------------------------------------------------------------
package rtpwl_pkg;

    // Number of calibration points and of segments between them.
    localparam int NPTS = 12;
    localparam int NSEG = NPTS - 1;

    // Field widths.
    localparam int RES_W  = 16;
    localparam int TEMP_W = 21;
    localparam int SEG_W  = 4;
    localparam int DT_W   = 5;
    localparam int T0_W   = 9;

    // Saturation limits of the temperature field.
    localparam int TEMP_MAX = 1048575;
    localparam int TEMP_MIN = -1048576;

    // Segment index.
    typedef logic [SEG_W-1:0] seg_t;

    // Calibration points: resistance in whole ohms, temperature in whole degC.
    localparam int PT_RES [NPTS] = '{21, 22, 24, 25, 27, 28, 30, 32, 33, 35, 36, 37};
    localparam int PT_TMP [NPTS] =
        '{-175, -169, -158, -148, -122, -102, -84, -56, -36, -13, 10, 23};

    // Temperature rise over each segment, in whole degC (all positive).
    localparam logic [DT_W-1:0] SEG_DT [NSEG] =
        '{5'd6, 5'd11, 5'd10, 5'd26, 5'd20, 5'd18, 5'd28, 5'd20, 5'd23, 5'd23, 5'd13};

    // Set where a segment spans two ohms instead of one.
    localparam logic SEG_WIDE [NSEG] =
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

endpackage

### design/resistance_to_temperature_pwl.sv
// ----------------------------------------------------------------------------
// resistance_to_temperature_pwl: piecewise-linear resistance to temperature
// Maps a fixed-point resistance onto a 12-point calibration curve and
// returns the floored temperature in 1/256 degC with a status bit.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                              | Handshake
//  ---------+------------------------------------+------------------------------
//  input    | resistance                         | start high while busy is low
//  result   | temperature, status                | done high for one cycle
//
//  One item may enter in every cycle; busy never rises.
//  Four register stages: segment search, offset from the segment base, slope
//  multiply, then shift, add and clamp; done is registered with the result.
//  Each stage carries a valid bit, so idle cycles between items cost nothing.
//  Reset clears the valid bits only; data registers hold whatever they had.
//  The receiver must take each result in the cycle done is high.
// ----------------------------------------------------------------------------
module resistance_to_temperature_pwl #(
    parameter int RES_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rtpwl_pkg::RES_W-1:0]       resistance,
    output logic                              done,
    output logic signed [rtpwl_pkg::TEMP_W-1:0] temperature,
    output logic                              status
);

    // Largest input that counts as an unmeasurable resistance (<= 0.001 ohm).
    localparam int NA_MAX = (1 << RES_FRAC_BITS) / 1000;
    // Offset width: covers the whole input range and the farthest table base.
    localparam int DW  = (RES_FRAC_BITS + 7 > 17) ? RES_FRAC_BITS + 7 : 17;
    // Product width and the width of the scaled sum.
    localparam int PW  = DW + 6;
    localparam int SW  = PW + 9;
    localparam int CW  = rtpwl_pkg::RES_W + 7 + RES_FRAC_BITS;

    // Stage 1: segment and unavailable flag.
    logic                        v1_reg;
    logic [rtpwl_pkg::RES_W-1:0] x1_reg;
    rtpwl_pkg::seg_t             seg1_reg;
    logic                        na1_reg;
    rtpwl_pkg::seg_t             seg1_next;

    // Stage 2: offset into the segment.
    logic                                v2_reg;
    logic signed [DW-1:0]                d2_reg;
    logic [rtpwl_pkg::DT_W-1:0]          dt2_reg;
    logic                                wide2_reg;
    logic signed [rtpwl_pkg::T0_W-1:0]   t02_reg;
    logic                                na2_reg;
    logic signed [DW-1:0]                d2_next;

    // Stage 3: slope product.
    logic                                v3_reg;
    logic signed [PW-1:0]                p3_reg;
    logic                                wide3_reg;
    logic signed [rtpwl_pkg::T0_W-1:0]   t03_reg;
    logic                                na3_reg;
    logic signed [PW-1:0]                p3_next;

    // Output stage.
    logic                                    done_reg;
    logic signed [rtpwl_pkg::TEMP_W-1:0]     temp_reg;
    logic                                    status_reg;
    logic signed [SW-1:0]                    pw_ext;
    logic signed [SW-1:0]                    frac_q;
    logic signed [SW-1:0]                    sum;
    logic signed [rtpwl_pkg::TEMP_W-1:0]     temp_next;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Segment search: count the interior points that the input lies above.
    always_comb
    begin
        seg1_next = '0;
        for (int i = 1; i < rtpwl_pkg::NSEG; i++)
        begin
            if (CW'(resistance) > CW'(rtpwl_pkg::PT_RES[i] * (1 << RES_FRAC_BITS)))
            begin
                seg1_next = seg1_next + rtpwl_pkg::seg_t'(1);
            end
        end
    end

    // Offset of the input from the lower point of its segment.
    assign d2_next = signed'(DW'({1'b0, x1_reg}))
                   - signed'(DW'(rtpwl_pkg::PT_RES[seg1_reg] * (1 << RES_FRAC_BITS)));

    // Offset times the segment's temperature rise.
    assign p3_next = d2_reg * signed'({1'b0, dt2_reg});

    // Scale to 1/256 degC, divide by the span (a floor shift), add base, clamp, zero if NA.
    always_comb
    begin
        pw_ext = SW'(p3_reg);
        if (wide3_reg)
        begin
            frac_q = (pw_ext <<< 8) >>> (RES_FRAC_BITS + 1);
        end
        else
        begin
            frac_q = (pw_ext <<< 8) >>> RES_FRAC_BITS;
        end
        sum = frac_q + (SW'(t03_reg) <<< 8);
        if (sum > SW'(rtpwl_pkg::TEMP_MAX))
        begin
            temp_next = rtpwl_pkg::TEMP_W'(rtpwl_pkg::TEMP_MAX);
        end
        else if (sum < SW'(rtpwl_pkg::TEMP_MIN))
        begin
            temp_next = rtpwl_pkg::TEMP_W'(rtpwl_pkg::TEMP_MIN);
        end
        else
        begin
            temp_next = sum[rtpwl_pkg::TEMP_W-1:0];
        end
        if (na3_reg)
        begin
            temp_next = '0;
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Data registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg   <= resistance;
            seg1_reg <= seg1_next;
            na1_reg  <= (CW'(resistance) <= CW'(NA_MAX));
        end
        if (v1_reg)
        begin
            d2_reg    <= d2_next;
            dt2_reg   <= rtpwl_pkg::SEG_DT[seg1_reg];
            wide2_reg <= rtpwl_pkg::SEG_WIDE[seg1_reg];
            t02_reg   <= rtpwl_pkg::T0_W'(rtpwl_pkg::PT_TMP[seg1_reg]);
            na2_reg   <= na1_reg;
        end
        if (v2_reg)
        begin
            p3_reg    <= p3_next;
            wide3_reg <= wide2_reg;
            t03_reg   <= t02_reg;
            na3_reg   <= na2_reg;
        end
        if (v3_reg)
        begin
            temp_reg   <= temp_next;
            status_reg <= na3_reg;
        end
    end

    assign done        = done_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

endmodule

### design/rtpwl_checker.sv
// ----------------------------------------------------------------------------
// rtpwl_checker: port-level checks for the resistance-to-temperature block
// Watches item entry and result timing and the unavailable-status rules.
// ----------------------------------------------------------------------------
module rtpwl_checker #(
    parameter int RES_FRAC_BITS = 8
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [rtpwl_pkg::RES_W-1:0]         resistance,
    input logic                                done,
    input logic signed [rtpwl_pkg::TEMP_W-1:0] temperature,
    input logic                                status
);

    // Every accepted item yields a result strobe on done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##3 done)
        else $error("result missing four cycles after an accepted item");

    // No result strobe without a matching accepted item.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##3 !done)
        else $error("result without an accepted item");

    // An unavailable result carries a zero temperature.
    a_na_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (temperature == '0))
        else $error("unavailable result with nonzero temperature");

    // Status follows the resistance of the item that produced the result.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ((32'($past(resistance, 4)) * 32'd1000)
                             <= (32'd1 << RES_FRAC_BITS))))
        else $error("status does not match the input resistance");

endmodule

bind resistance_to_temperature_pwl rtpwl_checker #(
    .RES_FRAC_BITS(RES_FRAC_BITS)
) u_rtpwl_checker (.*);

### tb/sv/rtpwl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtpwl_checker: result checker for the resistance-to-temperature converter
// Watches the input and result channels of the converter. For every accepted
// item it computes the expected temperature and status from its own copy of
// the calibration curve, then compares each result strobe against the oldest
// expected result. A running count of errors goes back to the testbench top.
// ----------------------------------------------------------------------------
module tb_rtpwl_checker #(
    parameter int RES_FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [rtpwl_pkg::RES_W-1:0]        resistance,
    input  logic                               done,
    input  logic signed [rtpwl_pkg::TEMP_W-1:0] temperature,
    input  logic                               status,
    output int                                 mismatches,
    output int                                 pending
);

    localparam int     CURVE_PTS = 12;
    localparam int     REPORT_MAX = 10;
    localparam longint SAT_HI = 1048575;
    localparam longint SAT_LO = -1048576;

    // Calibration curve: whole ohms against whole degC.
    localparam longint CAL_OHM [CURVE_PTS] =
        '{21, 22, 24, 25, 27, 28, 30, 32, 33, 35, 36, 37};
    localparam longint CAL_DEGC [CURVE_PTS] =
        '{-175, -169, -158, -148, -122, -102, -84, -56, -36, -13, 10, 23};

    typedef struct packed {
        logic signed [rtpwl_pkg::TEMP_W-1:0] temperature;
        logic                                status;
    } reading_t;

    reading_t readings_due [$];

    // Interpolates one resistance along the curve and floors to 1/256 degC.
    function automatic reading_t interpolate_reading(logic [rtpwl_pkg::RES_W-1:0] ohms_q);
        reading_t r;
        longint   unit;
        longint   x;
        longint   d;
        longint   num;
        longint   den;
        longint   q;
        longint   t;
        int       seg;
        int       i;
        unit = longint'(1) << RES_FRAC_BITS;
        x = longint'(ohms_q);
        r.temperature = '0;
        r.status = 1'b0;
        // A resistance of a milliohm or less cannot be measured.
        if (x * 1000 <= unit)
        begin
            r.status = 1'b1;
            return r;
        end
        // First segment whose upper point is at or above the input; the last
        // segment also covers everything above the curve.
        seg = CURVE_PTS - 2;
        for (i = CURVE_PTS - 1; i >= 1; i--)
        begin
            if (x <= CAL_OHM[i] * unit)
                seg = i - 1;
        end
        d = x - CAL_OHM[seg] * unit;
        num = d * (CAL_DEGC[seg + 1] - CAL_DEGC[seg]) * 256;
        den = (CAL_OHM[seg + 1] - CAL_OHM[seg]) * unit;
        // Division truncates toward zero, so adjust negative remainders down.
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        t = CAL_DEGC[seg] * 256 + q;
        if (t > SAT_HI)
            t = SAT_HI;
        if (t < SAT_LO)
            t = SAT_LO;
        r.temperature = t[rtpwl_pkg::TEMP_W-1:0];
        return r;
    endfunction

    // Queue expectations for accepted items and check each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            readings_due.delete();
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (readings_due.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: result with no item outstanding: %s%0d status=%0b",
                                 $realtime, "temp=", temperature, status);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (temperature !== want.temperature || status !== want.status)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display({"%0t: wrong result: expected temp=%0d status=%0b,",
                                      " got temp=%0d status=%0b"},
                                     $realtime, want.temperature, want.status,
                                     temperature, status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                readings_due.push_back(interpolate_reading(resistance));
            pending <= readings_due.size();
        end
    end

endmodule

### tb/sv/tb_resistance_to_temperature_pwl.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resistance_to_temperature_pwl: testbench for the resistance converter
// Drives directed items at the calibration points, the curve ends and the
// extremes of the resistance field, then random items in phases with
// different amounts of sender idling. A separate checker predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_resistance_to_temperature_pwl;

    localparam int FRAC_BITS      = 8;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [rtpwl_pkg::RES_W-1:0]         resistance = '0;
    logic                                done;
    logic signed [rtpwl_pkg::TEMP_W-1:0] temperature;
    logic                                status;
    int                                  mismatches;
    int                                  pending;
    int                                  quiet_cycles = 0;

    resistance_to_temperature_pwl #(
        .RES_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .resistance (resistance),
        .done       (done),
        .temperature(temperature),
        .status     (status)
    );

    tb_rtpwl_checker #(
        .RES_FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .resistance (resistance),
        .done       (done),
        .temperature(temperature),
        .status     (status),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: ends the run if nothing is accepted on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one item, after a random number of idle cycles, and holds it
    // until it is accepted. Called and returns at a falling edge.
    task automatic send_item(input logic [rtpwl_pkg::RES_W-1:0] ohms_q, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        resistance <= ohms_q;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results;
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Picks a random resistance, weighted toward the calibrated span.
    function automatic logic [rtpwl_pkg::RES_W-1:0] pick_resistance;
        int  sel;
        int  pt;
        sel = $urandom_range(99);
        pt = $urandom_range(rtpwl_pkg::NPTS - 1);
        if (sel < 55)
            return rtpwl_pkg::RES_W'($urandom_range(38 << FRAC_BITS, 20 << FRAC_BITS));
        else if (sel < 72)
            return rtpwl_pkg::RES_W'((rtpwl_pkg::PT_RES[pt] << FRAC_BITS)
                                     + $urandom_range(6) - 3);
        else if (sel < 82)
            return rtpwl_pkg::RES_W'($urandom_range(255));
        else if (sel < 85)
            return '0;
        else
            return rtpwl_pkg::RES_W'($urandom_range(16'hFFFF));
    endfunction

    initial
    begin
        logic [rtpwl_pkg::RES_W-1:0] directed [$];
        int                          idle_pct [3];
        int                          n;
        int                          ph;

        directed = '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'h8000, 16'h7FFF,
                     16'd5375, 16'd5376, 16'd5632, 16'd6145, 16'd6400,
                     16'd7040, 16'd7168, 16'd7679, 16'd8192, 16'd8525,
                     16'd8960, 16'd9216, 16'd9471, 16'd9472, 16'd9473,
                     16'd12345, 16'h5555, 16'hAAAA};
        idle_pct = '{0, 46, 20};

        // Hold reset from the start, then release it at a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items: curve ends, calibration points and field extremes.
        foreach (directed[i])
            send_item(directed[i], 0);
        drain_results();

        // Random items in phases of different sender idling.
        for (ph = 0; ph < 3; ph++)
        begin
            for (n = 0; n < RANDOM_ITEMS / 3; n++)
                send_item(pick_resistance(), idle_pct[ph]);
            drain_results();
        end

        // Let the pipeline settle before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
